// File: rtl/core/cejt_pkg.sv
// ----------------------------------------------------------------------------
// cejt_pkg
// Shared sizes, codes and controller/datapath interface types of the
// capability export and join table.
// ----------------------------------------------------------------------------
package cejt_pkg;

  localparam int EXPORT_ENTRIES = 16;
  localparam int EXP_W          = $clog2(EXPORT_ENTRIES);
  localparam int JOIN_SLOTS     = 4;
  localparam int SLOT_W         = $clog2(JOIN_SLOTS);
  localparam int JOIN_PARTS     = 8;
  localparam int PART_W         = $clog2(JOIN_PARTS);
  localparam int PTOT_W         = $clog2(JOIN_PARTS + 1);
  localparam int REF_W          = 16;
  localparam int SRV_W          = 16;
  localparam int TGT_W          = EXP_W + 1;
  localparam int RAM_W          = 32 + TGT_W;
  localparam int RAM_DEPTH      = JOIN_SLOTS * JOIN_PARTS;
  localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};

  // Request types.
  localparam logic [2:0] REQ_EXPORT  = 3'd0;
  localparam logic [2:0] REQ_BOOT    = 3'd1;
  localparam logic [2:0] REQ_CALL    = 3'd2;
  localparam logic [2:0] REQ_FINISH  = 3'd3;
  localparam logic [2:0] REQ_RELEASE = 3'd4;
  localparam logic [2:0] REQ_JOIN    = 3'd5;

  // Result kinds.
  localparam logic [2:0] RES_EXPORT = 3'd0;
  localparam logic [2:0] RES_BOOT   = 3'd1;
  localparam logic [2:0] RES_CALL   = 3'd2;
  localparam logic [2:0] RES_EXC    = 3'd3;
  localparam logic [2:0] RES_JOIN   = 3'd4;
  localparam logic [2:0] RES_UNIMP  = 3'd5;

  // Error codes.
  localparam logic [1:0] ERR_NO_BOOT = 2'd0;
  localparam logic [1:0] ERR_FULL    = 2'd1;
  localparam logic [1:0] ERR_NO_EXP  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_BOOT_PRESENT = 1'b0;
  localparam logic CFG_BOOT_SERVER  = 1'b1;

  typedef struct packed {
    logic              accept;
    logic              cmp;
    logic              emit;
    logic              first;
    logic              last;
    logic [PART_W-1:0] part;
  } cejt_cmd_t;

  typedef struct packed {
    logic              join_done;
    logic [PTOT_W-1:0] total;
  } cejt_status_t;

endpackage

// File: rtl/core/capability_export_and_join_table_core.sv
// ----------------------------------------------------------------------------
// capability_export_and_join_table_core
// Reference-counted export table and join assembly for one RPC connection.
//
//   Channel  | Handshake              | Payload
//   ---------+------------------------+-------------------------------------
//   request  | start_i / busy_o       | req_type_i .. part_number_i
//   result   | result_strobe_o        | result_kind_o .. last_o
//   config   | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// A request is taken when start_i is high and busy_o is low. Every request
// except a completing join part is handled in the cycle it is taken; its
// single result, if any, shows in the next cycle. A join part that
// completes its set makes the block busy while the per-part store, which
// has one read port and registered read data, is read twice per part (once
// to check the targets, once to emit). Each result is shown for exactly
// one cycle and the receiver cannot stall it. Reset clears both tables
// and the configuration; the per-part store needs no clearing since a
// slot only reads parts it has written.
// ----------------------------------------------------------------------------
module capability_export_and_join_table_core import cejt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  req_type_i,
  input  logic [31:0] question_id_i,
  input  logic [15:0] server_id_i,
  input  logic        target_valid_i,
  input  logic [31:0] cap_index_i,
  input  logic [31:0] release_count_i,
  input  logic        key_part_present_i,
  input  logic [31:0] join_key_i,
  input  logic [15:0] part_total_i,
  input  logic [15:0] part_number_i,
  output logic        result_strobe_o,
  output logic [2:0]  result_kind_o,
  output logic [31:0] answer_id_o,
  output logic [3:0]  export_index_o,
  output logic        export_valid_o,
  output logic [1:0]  error_code_o,
  output logic [31:0] result_join_key_o,
  output logic        join_succeeded_o,
  output logic        carries_cap_o,
  output logic        last_o
);

  cejt_cmd_t    cmd;
  cejt_status_t status;

  // The controller only sequences; all table state lives in the datapath.
  cejt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  cejt_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .req_type_i         (req_type_i),
    .question_id_i      (question_id_i),
    .server_id_i        (server_id_i),
    .target_valid_i     (target_valid_i),
    .cap_index_i        (cap_index_i),
    .release_count_i    (release_count_i),
    .key_part_present_i (key_part_present_i),
    .join_key_i         (join_key_i),
    .part_total_i       (part_total_i),
    .part_number_i      (part_number_i),
    .result_strobe_o    (result_strobe_o),
    .result_kind_o      (result_kind_o),
    .answer_id_o        (answer_id_o),
    .export_index_o     (export_index_o),
    .export_valid_o     (export_valid_o),
    .error_code_o       (error_code_o),
    .result_join_key_o  (result_join_key_o),
    .join_succeeded_o   (join_succeeded_o),
    .carries_cap_o      (carries_cap_o),
    .last_o             (last_o)
  );

endmodule

// File: rtl/core/cejt_ram.sv
// ----------------------------------------------------------------------------
// cejt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cejt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/cejt_ctrl.sv
// ----------------------------------------------------------------------------
// cejt_ctrl
// Controller: accepts requests and sequences the check and emit passes
// over the parts of a completed join set.
// ----------------------------------------------------------------------------
module cejt_ctrl import cejt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  output logic         busy_o,
  input  cejt_status_t status_i,
  output cejt_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CHK_RD  = 3'd1;
  localparam logic [2:0] S_CHK_CMP = 3'd2;
  localparam logic [2:0] S_EM_RD   = 3'd3;
  localparam logic [2:0] S_EM_OUT  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [PART_W-1:0] cnt_q, cnt_d;
  logic              is_last;

  assign is_last = ({1'b0, cnt_q} + PTOT_W'(1)) == status_i.total;
  assign busy_o  = state_q != S_IDLE;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmd_o        = '0;
    cmd_o.part   = cnt_q;
    cmd_o.first  = cnt_q == '0;
    cmd_o.last   = is_last;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.accept = start_i;
        if (start_i && status_i.join_done) begin
          state_d = S_CHK_RD;
          cnt_d   = '0;
        end
      end
      S_CHK_RD: begin
        state_d = S_CHK_CMP;
      end
      S_CHK_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = S_CHK_RD;
        cnt_d     = cnt_q + PART_W'(1);
        if (is_last) begin
          state_d = S_EM_RD;
          cnt_d   = '0;
        end
      end
      S_EM_RD: begin
        state_d = S_EM_OUT;
      end
      S_EM_OUT: begin
        cmd_o.emit = 1'b1;
        state_d    = S_EM_RD;
        cnt_d      = cnt_q + PART_W'(1);
        if (is_last) begin
          state_d = S_IDLE;
          cnt_d   = '0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: rtl/core/cejt_datapath.sv
// ----------------------------------------------------------------------------
// cejt_datapath
// Export table, join slot table, per-part store and result registers.
// ----------------------------------------------------------------------------
module cejt_datapath import cejt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cejt_cmd_t          cmd_i,
  output cejt_status_t       status_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [SRV_W-1:0]   cfg_data_i,
  input  logic [2:0]         req_type_i,
  input  logic [31:0]        question_id_i,
  input  logic [15:0]        server_id_i,
  input  logic               target_valid_i,
  input  logic [31:0]        cap_index_i,
  input  logic [31:0]        release_count_i,
  input  logic               key_part_present_i,
  input  logic [31:0]        join_key_i,
  input  logic [15:0]        part_total_i,
  input  logic [15:0]        part_number_i,
  output logic               result_strobe_o,
  output logic [2:0]         result_kind_o,
  output logic [31:0]        answer_id_o,
  output logic [3:0]         export_index_o,
  output logic               export_valid_o,
  output logic [1:0]         error_code_o,
  output logic [31:0]        result_join_key_o,
  output logic               join_succeeded_o,
  output logic               carries_cap_o,
  output logic               last_o
);

  logic              boot_present_q;
  logic [SRV_W-1:0]  boot_server_q;

  logic [EXPORT_ENTRIES-1:0] used_q;
  logic [SRV_W-1:0]          server_q [EXPORT_ENTRIES];
  logic [REF_W-1:0]          ref_q    [EXPORT_ENTRIES];

  logic [JOIN_SLOTS-1:0] sused_q;
  logic [31:0]           skey_q  [JOIN_SLOTS];
  logic [PTOT_W-1:0]     stot_q  [JOIN_SLOTS];
  logic [PTOT_W-1:0]     scnt_q  [JOIN_SLOTS];
  logic [JOIN_PARTS-1:0] smask_q [JOIN_SLOTS];

  logic [SLOT_W-1:0] jslot_q;
  logic [PTOT_W-1:0] jtot_q;
  logic [31:0]       jkey_q;
  logic [TGT_W-1:0]  first_q;
  logic              same_q;

  // Export search.
  logic [SRV_W-1:0] srv;
  logic             hit_any, free_any, exp_ok;
  logic [EXP_W-1:0] hit_idx, free_idx, exp_idx;
  logic             do_export;

  always_comb begin
    srv      = (req_type_i == REQ_EXPORT) ? server_id_i : boot_server_q;
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = EXPORT_ENTRIES - 1; i >= 0; i--) begin
      if (used_q[i] && server_q[i] == srv) begin
        hit_any = 1'b1;
        hit_idx = EXP_W'(i);
      end
      if (!used_q[i]) begin
        free_any = 1'b1;
        free_idx = EXP_W'(i);
      end
    end
    exp_ok  = hit_any || free_any;
    exp_idx = hit_any ? hit_idx : free_idx;
  end

  assign do_export = cmd_i.accept &&
                     (req_type_i == REQ_EXPORT || (req_type_i == REQ_BOOT && boot_present_q));

  // Target resolution; also the release id check.
  logic             id_in_range, res_ok;
  logic [EXP_W-1:0] ridx;
  logic [TGT_W-1:0] tgt;

  assign ridx        = cap_index_i[EXP_W-1:0];
  assign id_in_range = cap_index_i[31:EXP_W] == '0;
  assign res_ok      = target_valid_i && id_in_range && used_q[ridx];
  assign tgt         = res_ok ? {1'b1, ridx} : '0;

  // Join slot search.
  logic              m_any, f_any, s_ok, jmal, dup, join_ok, join_done;
  logic [SLOT_W-1:0] m_idx, f_idx, s_sel;
  logic [PART_W-1:0] num;
  logic [PTOT_W-1:0] tot;
  logic [JOIN_PARTS-1:0] mask_cur;
  logic [PTOT_W-1:0] cnt_cur;

  always_comb begin
    m_any = 1'b0;
    f_any = 1'b0;
    m_idx = '0;
    f_idx = '0;
    for (int i = JOIN_SLOTS - 1; i >= 0; i--) begin
      if (sused_q[i] && skey_q[i] == join_key_i) begin
        m_any = 1'b1;
        m_idx = SLOT_W'(i);
      end
      if (!sused_q[i]) begin
        f_any = 1'b1;
        f_idx = SLOT_W'(i);
      end
    end
  end

  assign tot      = part_total_i[PTOT_W-1:0];
  assign num      = part_number_i[PART_W-1:0];
  assign jmal     = part_total_i == '0 || part_total_i > 16'(JOIN_PARTS) ||
                    part_number_i >= part_total_i;
  assign s_sel    = m_any ? m_idx : f_idx;
  assign s_ok     = m_any ? (stot_q[m_idx] == tot) : f_any;
  assign mask_cur = m_any ? smask_q[m_idx] : '0;
  assign cnt_cur  = m_any ? scnt_q[m_idx] : '0;
  assign dup      = mask_cur[num];
  assign join_ok  = req_type_i == REQ_JOIN && key_part_present_i && !jmal && s_ok && !dup;
  assign join_done = join_ok && (cnt_cur + PTOT_W'(1)) == tot;

  assign status_o.join_done = join_done;
  assign status_o.total     = jtot_q;

  // Per-part store: question id and resolved target.
  logic [RAM_W-1:0] rdata;
  logic [TGT_W-1:0] tgt_rd;

  cejt_ram #(.WIDTH(RAM_W), .DEPTH(RAM_DEPTH)) u_parts (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && join_ok),
    .waddr_i ({s_sel, num}),
    .wdata_i ({question_id_i, tgt}),
    .raddr_i ({jslot_q, cmd_i.part}),
    .rdata_o (rdata)
  );

  assign tgt_rd = rdata[TGT_W-1:0];

  logic cap;
  assign cap = cmd_i.emit && cmd_i.first && same_q;

  // Tables and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_present_q <= 1'b0;
      boot_server_q  <= '0;
      used_q         <= '0;
      sused_q        <= '0;
      for (int i = 0; i < EXPORT_ENTRIES; i++) begin
        server_q[i] <= '0;
        ref_q[i]    <= '0;
      end
      for (int i = 0; i < JOIN_SLOTS; i++) begin
        skey_q[i]  <= '0;
        stot_q[i]  <= '0;
        scnt_q[i]  <= '0;
        smask_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_BOOT_PRESENT: boot_present_q <= cfg_data_i[0];
          CFG_BOOT_SERVER:  boot_server_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (do_export && exp_ok) begin
        if (hit_any) begin
          if (ref_q[hit_idx] != REF_MAX) begin
            ref_q[hit_idx] <= ref_q[hit_idx] + REF_W'(1);
          end
        end else begin
          used_q[free_idx]   <= 1'b1;
          server_q[free_idx] <= srv;
          ref_q[free_idx]    <= REF_W'(1);
        end
      end
      if (cmd_i.accept && req_type_i == REQ_RELEASE && id_in_range && used_q[ridx]) begin
        if (release_count_i >= {{(32 - REF_W){1'b0}}, ref_q[ridx]}) begin
          used_q[ridx]   <= 1'b0;
          server_q[ridx] <= '0;
          ref_q[ridx]    <= '0;
        end else begin
          ref_q[ridx] <= ref_q[ridx] - release_count_i[REF_W-1:0];
        end
      end
      if (cmd_i.accept && join_ok) begin
        sused_q[s_sel] <= 1'b1;
        skey_q[s_sel]  <= join_key_i;
        stot_q[s_sel]  <= tot;
        scnt_q[s_sel]  <= cnt_cur + PTOT_W'(1);
        smask_q[s_sel] <= mask_cur | (JOIN_PARTS'(1) << num);
      end
      if (cap && ref_q[first_q[EXP_W-1:0]] != REF_MAX) begin
        ref_q[first_q[EXP_W-1:0]] <= ref_q[first_q[EXP_W-1:0]] + REF_W'(1);
      end
      if (cmd_i.emit && cmd_i.last) begin
        sused_q[jslot_q] <= 1'b0;
        skey_q[jslot_q]  <= '0;
        stot_q[jslot_q]  <= '0;
        scnt_q[jslot_q]  <= '0;
        smask_q[jslot_q] <= '0;
      end
    end
  end

  // Completed join set context and the check pass.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && join_done) begin
      jslot_q <= s_sel;
      jtot_q  <= tot;
      jkey_q  <= join_key_i;
    end
    if (cmd_i.cmp) begin
      if (cmd_i.first) begin
        first_q <= tgt_rd;
        same_q  <= tgt_rd[TGT_W-1];
      end else begin
        same_q <= same_q && tgt_rd == first_q;
      end
    end
  end

  // Result registers.
  logic        strobe_d;
  logic [2:0]  kind_d;
  logic [31:0] aid_d, jk_d;
  logic [3:0]  eidx_d;
  logic        evalid_d, succ_d, capo_d, last_d;
  logic [1:0]  err_d;

  always_comb begin
    strobe_d = 1'b0;
    kind_d   = RES_EXPORT;
    aid_d    = question_id_i;
    eidx_d   = '0;
    evalid_d = 1'b0;
    err_d    = ERR_NO_BOOT;
    jk_d     = '0;
    succ_d   = 1'b0;
    capo_d   = 1'b0;
    last_d   = 1'b1;
    if (cmd_i.emit) begin
      strobe_d = 1'b1;
      kind_d   = RES_JOIN;
      aid_d    = rdata[RAM_W-1:TGT_W];
      eidx_d   = cap ? 4'(first_q[EXP_W-1:0]) : '0;
      evalid_d = cap;
      capo_d   = cap;
      succ_d   = same_q;
      jk_d     = jkey_q;
      last_d   = cmd_i.last;
    end else if (cmd_i.accept) begin
      strobe_d = 1'b1;
      unique case (req_type_i)
        REQ_EXPORT: begin
          kind_d = RES_EXPORT;
          if (exp_ok) begin
            eidx_d   = 4'(exp_idx);
            evalid_d = 1'b1;
          end else begin
            err_d = ERR_FULL;
          end
        end
        REQ_BOOT: begin
          if (!boot_present_q) begin
            kind_d = RES_EXC;
          end else if (exp_ok) begin
            kind_d   = RES_BOOT;
            eidx_d   = 4'(exp_idx);
            evalid_d = 1'b1;
          end else begin
            kind_d = RES_EXC;
            err_d  = ERR_FULL;
          end
        end
        REQ_CALL: begin
          if (res_ok) begin
            kind_d   = RES_CALL;
            eidx_d   = 4'(ridx);
            evalid_d = 1'b1;
          end else begin
            kind_d = RES_EXC;
            err_d  = ERR_NO_EXP;
          end
        end
        REQ_FINISH, REQ_RELEASE: begin
          strobe_d = 1'b0;
        end
        REQ_JOIN: begin
          kind_d = RES_JOIN;
          jk_d   = key_part_present_i ? join_key_i : '0;
          if (join_ok) begin
            strobe_d = 1'b0;
          end
        end
        default: begin
          kind_d = RES_UNIMP;
          aid_d  = '0;
        end
      endcase
    end
  end

  logic        strobe_q;
  logic [2:0]  kind_q;
  logic [31:0] aid_q, jk_q;
  logic [3:0]  eidx_q;
  logic        evalid_q, succ_q, capo_q, last_q;
  logic [1:0]  err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    aid_q    <= aid_d;
    eidx_q   <= eidx_d;
    evalid_q <= evalid_d;
    err_q    <= err_d;
    jk_q     <= jk_d;
    succ_q   <= succ_d;
    capo_q   <= capo_d;
    last_q   <= last_d;
  end

  assign result_strobe_o   = strobe_q;
  assign result_kind_o     = kind_q;
  assign answer_id_o       = aid_q;
  assign export_index_o    = eidx_q;
  assign export_valid_o    = evalid_q;
  assign error_code_o      = err_q;
  assign result_join_key_o = jk_q;
  assign join_succeeded_o  = succ_q;
  assign carries_cap_o     = capo_q;
  assign last_o            = last_q;

endmodule

// File: rtl/core/cejt_checker.sv
// ----------------------------------------------------------------------------
// cejt_assert
// Port-level checks of the result sequence, bound to the top level.
// ----------------------------------------------------------------------------
module cejt_assert import cejt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [2:0]  req_type_i,
  input logic        result_strobe_o,
  input logic [2:0]  result_kind_o,
  input logic        export_valid_o,
  input logic        join_succeeded_o,
  input logic        carries_cap_o,
  input logic        last_o
);

  // More results of the same request are still to come.
  a_more_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !last_o |-> busy_o)
    else $error("non-final result while idle");

  a_cap_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && carries_cap_o |->
      export_valid_o && join_succeeded_o && result_kind_o == RES_JOIN)
    else $error("capability on a result that is not a successful join");

  a_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && result_kind_o != RES_JOIN |-> last_o)
    else $error("non-join result not marked final");

  a_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (req_type_i == REQ_FINISH || req_type_i == REQ_RELEASE)
      |=> !result_strobe_o)
    else $error("finish or release produced a result");

endmodule

bind capability_export_and_join_table_core cejt_assert u_cejt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .req_type_i       (req_type_i),
  .result_strobe_o  (result_strobe_o),
  .result_kind_o    (result_kind_o),
  .export_valid_o   (export_valid_o),
  .join_succeeded_o (join_succeeded_o),
  .carries_cap_o    (carries_cap_o),
  .last_o           (last_o)
);

// File: sim/cejt_checker.sv
// ----------------------------------------------------------------------------
// cejt_checker
// Watches the request, configuration and result channels of the export and
// join table, keeps its own copy of both tables, and compares every result
// transfer with the oldest predicted answer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cejt_checker import cejt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [2:0]  req_type_i,
  input  logic [31:0] question_id_i,
  input  logic [15:0] server_id_i,
  input  logic        target_valid_i,
  input  logic [31:0] cap_index_i,
  input  logic [31:0] release_count_i,
  input  logic        key_part_present_i,
  input  logic [31:0] join_key_i,
  input  logic [15:0] part_total_i,
  input  logic [15:0] part_number_i,
  input  logic        result_strobe_i,
  input  logic [2:0]  result_kind_i,
  input  logic [31:0] answer_id_i,
  input  logic [3:0]  export_index_i,
  input  logic        export_valid_i,
  input  logic [1:0]  error_code_i,
  input  logic [31:0] result_join_key_i,
  input  logic        join_succeeded_i,
  input  logic        carries_cap_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          answers_seen_o,
  output int          joins_won_o
);

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] aid;
    logic [3:0]  eidx;
    logic        evalid;
    logic [1:0]  err;
    logic [31:0] jkey;
    logic        succ;
    logic        cap;
    logic        last;
  } answer_t;

  answer_t answer_q[$];

  logic        boot_present;
  logic [15:0] boot_server;
  logic        exp_used   [EXPORT_ENTRIES];
  logic [15:0] exp_server [EXPORT_ENTRIES];
  logic [15:0] exp_refs   [EXPORT_ENTRIES];
  logic        slot_open  [JOIN_SLOTS];
  logic [31:0] slot_key   [JOIN_SLOTS];
  int          slot_total [JOIN_SLOTS];
  int          slot_count [JOIN_SLOTS];
  logic [JOIN_PARTS-1:0] slot_mask [JOIN_SLOTS];
  logic [31:0] part_qid   [JOIN_SLOTS][JOIN_PARTS];
  int          part_tgt   [JOIN_SLOTS][JOIN_PARTS];  // -1 when unresolved

  function automatic answer_t make_answer(logic [2:0] kind, logic [31:0] aid, int eidx,
                                          logic [1:0] err, logic [31:0] jkey,
                                          logic succ, logic cap, logic last);
    answer_t a;
    a.kind   = kind;
    a.aid    = aid;
    a.eidx   = (eidx >= 0) ? eidx[3:0] : 4'd0;
    a.evalid = (eidx >= 0);
    a.err    = err;
    a.jkey   = jkey;
    a.succ   = succ;
    a.cap    = cap;
    a.last   = last;
    return a;
  endfunction

  function automatic void bump_refs(int e);
    if (exp_refs[e] != REF_MAX) exp_refs[e] = exp_refs[e] + 16'd1;
  endfunction

  // Reuse the entry that already holds the server, else claim the lowest free one.
  function automatic int claim_export(logic [15:0] srv);
    for (int i = 0; i < EXPORT_ENTRIES; i++) begin
      if (exp_used[i] && exp_server[i] == srv) begin
        bump_refs(i);
        return i;
      end
    end
    for (int i = 0; i < EXPORT_ENTRIES; i++) begin
      if (!exp_used[i]) begin
        exp_used[i]   = 1'b1;
        exp_server[i] = srv;
        exp_refs[i]   = 16'd1;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic int live_target(logic valid, logic [31:0] idx);
    if (!valid || idx >= EXPORT_ENTRIES) return -1;
    return exp_used[idx[3:0]] ? int'(idx) : -1;
  endfunction

  function automatic int pick_slot(logic [31:0] key, int total);
    for (int i = 0; i < JOIN_SLOTS; i++)
      if (slot_open[i] && slot_key[i] == key) return (slot_total[i] == total) ? i : -1;
    for (int i = 0; i < JOIN_SLOTS; i++) begin
      if (!slot_open[i]) begin
        slot_open[i]  = 1'b1;
        slot_key[i]   = key;
        slot_total[i] = total;
        slot_count[i] = 0;
        slot_mask[i]  = '0;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void join_part();
    int s, first, total, num;
    logic same;
    total = part_total_i;
    num   = part_number_i;
    if (!key_part_present_i) begin
      answer_q.push_back(make_answer(RES_JOIN, question_id_i, -1, '0, '0, 0, 0, 1));
      return;
    end
    if (total == 0 || total > JOIN_PARTS || num >= total) begin
      answer_q.push_back(make_answer(RES_JOIN, question_id_i, -1, '0, join_key_i, 0, 0, 1));
      return;
    end
    s = pick_slot(join_key_i, total);
    if (s < 0 || slot_mask[s][num]) begin
      answer_q.push_back(make_answer(RES_JOIN, question_id_i, -1, '0, join_key_i, 0, 0, 1));
      return;
    end
    slot_mask[s][num] = 1'b1;
    part_qid[s][num]  = question_id_i;
    part_tgt[s][num]  = live_target(target_valid_i, cap_index_i);
    slot_count[s]++;
    if (slot_count[s] != slot_total[s]) return;
    // The set is complete: one answer per part, in part order.
    first = part_tgt[s][0];
    same  = (first >= 0);
    for (int i = 1; i < total; i++) if (part_tgt[s][i] != first) same = 1'b0;
    if (same) begin
      bump_refs(first);
      joins_won_o++;
    end
    for (int i = 0; i < total; i++)
      answer_q.push_back(make_answer(RES_JOIN, part_qid[s][i], (same && i == 0) ? first : -1,
                                     '0, join_key_i, same, same && i == 0, i + 1 == total));
    slot_open[s]  = 1'b0;
    slot_key[s]   = '0;
    slot_total[s] = 0;
    slot_count[s] = 0;
    slot_mask[s]  = '0;
  endfunction

  function automatic void predict_request();
    int e;
    case (req_type_i)
      REQ_EXPORT: begin
        e = claim_export(server_id_i);
        answer_q.push_back(make_answer(RES_EXPORT, question_id_i, e,
                                       (e < 0) ? ERR_FULL : ERR_NO_BOOT, '0, 0, 0, 1));
      end
      REQ_BOOT: begin
        if (!boot_present) begin
          answer_q.push_back(make_answer(RES_EXC, question_id_i, -1, ERR_NO_BOOT, '0, 0, 0, 1));
        end else begin
          e = claim_export(boot_server);
          if (e < 0)
            answer_q.push_back(make_answer(RES_EXC, question_id_i, -1, ERR_FULL, '0, 0, 0, 1));
          else
            answer_q.push_back(make_answer(RES_BOOT, question_id_i, e, ERR_NO_BOOT,
                                           '0, 0, 0, 1));
        end
      end
      REQ_CALL: begin
        e = live_target(target_valid_i, cap_index_i);
        if (e < 0)
          answer_q.push_back(make_answer(RES_EXC, question_id_i, -1, ERR_NO_EXP, '0, 0, 0, 1));
        else
          answer_q.push_back(make_answer(RES_CALL, question_id_i, e, ERR_NO_BOOT,
                                         '0, 0, 0, 1));
      end
      REQ_FINISH: ;
      REQ_RELEASE: begin
        if (cap_index_i < EXPORT_ENTRIES && exp_used[cap_index_i[3:0]]) begin
          e = cap_index_i;
          if (release_count_i >= exp_refs[e]) begin
            exp_used[e]   = 1'b0;
            exp_server[e] = '0;
            exp_refs[e]   = '0;
          end else begin
            exp_refs[e] = exp_refs[e] - release_count_i[15:0];
          end
        end
      end
      REQ_JOIN: join_part();
      default: answer_q.push_back(make_answer(RES_UNIMP, '0, -1, '0, '0, 0, 0, 1));
    endcase
  endfunction

  answer_t seen;
  assign seen = '{result_kind_i, answer_id_i, export_index_i, export_valid_i, error_code_i,
                  result_join_key_i, join_succeeded_i, carries_cap_i, last_i};
  assign pending_o = answer_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      answer_q.delete();
      boot_present = 1'b0;
      boot_server  = '0;
      for (int i = 0; i < EXPORT_ENTRIES; i++) begin
        exp_used[i] = 1'b0; exp_server[i] = '0; exp_refs[i] = '0;
      end
      for (int i = 0; i < JOIN_SLOTS; i++) begin
        slot_open[i] = 1'b0; slot_key[i] = '0; slot_total[i] = 0;
        slot_count[i] = 0; slot_mask[i] = '0;
      end
      fail_count_o   = 0;
      answers_seen_o = 0;
      joins_won_o    = 0;
    end else begin
      // Results are registered after their request is taken, so check first.
      if (result_strobe_i) begin
        answers_seen_o++;
        if (answer_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: unexpected result kind %0d answer %h", $realtime,
                     result_kind_i, answer_id_i);
        end else begin
          want = answer_q.pop_front();
          if (want != seen) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: mismatch kind/aid/idx/v/err/key/ok/cap/last exp %0d %h %0d %b %0d %h %b %b %b got %0d %h %0d %b %0d %h %b %b %b",
                       $realtime, want.kind, want.aid, want.eidx, want.evalid, want.err,
                       want.jkey, want.succ, want.cap, want.last, seen.kind, seen.aid,
                       seen.eidx, seen.evalid, seen.err, seen.jkey, seen.succ, seen.cap,
                       seen.last);
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_BOOT_PRESENT) boot_present = cfg_data_i[0];
        else boot_server = cfg_data_i;
      end
      if (start_i && !busy_i) predict_request();
    end
  end

endmodule

// File: sim/tb_capability_export_and_join_table_core.sv
// ----------------------------------------------------------------------------
// tb_capability_export_and_join_table_core
// Drives directed and random requests into the export and join table while
// the checker predicts every answer; the run goes through three sender idle
// profiles with different bootstrap settings and ends with a verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_capability_export_and_join_table_core;
  import cejt_pkg::*;

  // Request types the package leaves unnamed; the block answers them as unimplemented.
  localparam logic [2:0] REQ_OTHER = 3'd6;
  localparam logic [2:0] REQ_SPARE = 3'd7;
  localparam int CYCLE_LIMIT = 2_000_000;

  logic        clk_i, rst_ni;
  logic        cfg_we_i, cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        start_i, busy_o;
  logic [2:0]  req_type_i;
  logic [31:0] question_id_i, cap_index_i, release_count_i, join_key_i;
  logic [15:0] server_id_i, part_total_i, part_number_i;
  logic        target_valid_i, key_part_present_i;
  logic        result_strobe_o, export_valid_o, join_succeeded_o, carries_cap_o, last_o;
  logic [2:0]  result_kind_o;
  logic [31:0] answer_id_o, result_join_key_o;
  logic [3:0]  export_index_o;
  logic [1:0]  error_code_o;

  int fail_count, pending, answers_seen, joins_won;
  int requests_sent;
  int idle_pct;     // chance in percent that the sender pauses before a request
  int cycles;

  capability_export_and_join_table_core i_dut (.*);

  cejt_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .start_i, .busy_i(busy_o),
    .req_type_i, .question_id_i, .server_id_i, .target_valid_i, .cap_index_i,
    .release_count_i, .key_part_present_i, .join_key_i, .part_total_i, .part_number_i,
    .result_strobe_i(result_strobe_o), .result_kind_i(result_kind_o),
    .answer_id_i(answer_id_o), .export_index_i(export_index_o),
    .export_valid_i(export_valid_o), .error_code_i(error_code_o),
    .result_join_key_i(result_join_key_o), .join_succeeded_i(join_succeeded_o),
    .carries_cap_i(carries_cap_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending), .answers_seen_o(answers_seen),
    .joins_won_o(joins_won)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake must not stall the run forever.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("capability_export_and_join_table_core verification failed");
      $finish;
    end
  end

  // Present one request and hold it until the block takes it. The busy flag
  // is sampled at the falling edge, well clear of the edge that updates it.
  task automatic send_request(logic [2:0] kind, logic [31:0] qid, logic [15:0] srv,
                              logic tvalid, logic [31:0] idx, logic [31:0] cnt,
                              logic keyed, logic [31:0] key, logic [15:0] total,
                              logic [15:0] num);
    logic was_free;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start_i            <= 1'b1;
    req_type_i         <= kind;
    question_id_i      <= qid;
    server_id_i        <= srv;
    target_valid_i     <= tvalid;
    cap_index_i        <= idx;
    release_count_i    <= cnt;
    key_part_present_i <= keyed;
    join_key_i         <= key;
    part_total_i       <= total;
    part_number_i      <= num;
    do begin
      @(negedge clk_i);
      was_free = !busy_o;
      @(posedge clk_i);
    end while (!was_free);
    requests_sent++;
  endtask

  task automatic send_export(logic [15:0] srv);
    send_request(REQ_EXPORT, $urandom, srv, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom);
  endtask

  task automatic send_call(logic tvalid, logic [31:0] idx);
    send_request(REQ_CALL, $urandom, $urandom, tvalid, idx, $urandom, $urandom,
                 $urandom, $urandom, $urandom);
  endtask

  task automatic send_release(logic [31:0] idx, logic [31:0] cnt);
    send_request(REQ_RELEASE, $urandom, $urandom, $urandom, idx, cnt, $urandom,
                 $urandom, $urandom, $urandom);
  endtask

  task automatic send_join(logic keyed, logic [31:0] key, logic [15:0] total,
                           logic [15:0] num, logic tvalid, logic [31:0] idx);
    send_request(REQ_JOIN, $urandom, $urandom, tvalid, idx, $urandom, keyed, key, total, num);
  endtask

  // Let every predicted answer arrive, then wait longer so that a
  // request without an answer has surely retired too.
  task automatic drain();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0 || busy_o);
    repeat (4) @(posedge clk_i);
  endtask

  // The request line is dropped first so that the last request is not taken
  // a second time while the register write goes out.
  task automatic write_register(logic idx, logic [15:0] data);
    start_i    <= 1'b0;
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // A full join set with random content: mostly every part names the same
  // export, sometimes the targets scatter, a part repeats or the total slips.
  task automatic send_join_set();
    logic [31:0] key, idx;
    int total, order[JOIN_PARTS], tmp, j, flavor;
    key    = ($urandom_range(3) == 0) ? $urandom : $urandom_range(5);
    total  = $urandom_range(1, JOIN_PARTS);
    idx    = $urandom_range(15);
    flavor = $urandom_range(9);
    for (int i = 0; i < total; i++) order[i] = i;
    for (int i = total - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i]; order[i] = order[j]; order[j] = tmp;
    end
    for (int i = 0; i < total; i++) begin
      if (flavor == 0)
        send_join(1'b1, key, total, order[i], $urandom, $urandom_range(17));
      else
        send_join(1'b1, key, total, order[i], 1'b1, idx);
      if (flavor == 1 && i == 0 && total > 1)
        send_join(1'b1, key, total, order[0], 1'b1, idx);
      if (flavor == 2 && i == 0 && total > 1)
        send_join(1'b1, key, total - 1, 0, 1'b1, idx);
    end
  endtask

  task automatic send_random_request();
    int pick;
    pick = $urandom_range(99);
    if (pick < 20)
      send_export(($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(23)));
    else if (pick < 28)
      send_request(REQ_BOOT, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom);
    else if (pick < 42)
      send_call(($urandom_range(5) != 0),
                ($urandom_range(5) == 0) ? $urandom : $urandom_range(15));
    else if (pick < 46)
      send_request(REQ_FINISH, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom);
    else if (pick < 60)
      send_release(($urandom_range(7) == 0) ? $urandom : $urandom_range(15),
                   ($urandom_range(5) == 0) ? $urandom : $urandom_range(1, 3));
    else if (pick < 92)
      send_join_set();
    else if (pick < 96)
      send_join($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    else
      send_request(($urandom_range(1) == 0) ? REQ_OTHER : REQ_SPARE, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic run_phase(int pct, int count);
    int first;
    idle_pct = pct;
    first = requests_sent;
    while (requests_sent - first < count) send_random_request();
  endtask

  initial begin
    int e;
    cycles = 0; requests_sent = 0; idle_pct = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = 1'b0; cfg_data_i = '0;
    start_i = 1'b0; req_type_i = REQ_FINISH; question_id_i = '0; server_id_i = '0;
    target_valid_i = 1'b0; cap_index_i = '0; release_count_i = '0;
    key_part_present_i = 1'b0; join_key_i = '0; part_total_i = '0; part_number_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Bootstrap is absent after reset, so it must raise an exception.
    write_register(CFG_BOOT_PRESENT, 16'd0);
    send_request(REQ_BOOT, 32'hFFFF_FFFF, '1, 1'b1, '1, '1, 1'b1, '1, '1, '1);
    send_export(16'd0);
    send_export(16'hFFFF);
    send_export(16'hFFFF);                     // same server reuses its entry
    send_call(1'b1, 32'd0);
    send_call(1'b0, 32'd0);                    // no usable target
    send_call(1'b1, 32'hFFFF_FFFF);            // index far out of range
    send_call(1'b1, 32'd15);                   // entry never claimed
    send_request(REQ_FINISH, '0, '0, 1'b0, '0, '0, 1'b0, '0, '0, '0);
    send_request(REQ_OTHER, '1, '1, 1'b1, '1, '1, 1'b1, '1, '1, '1);
    send_request(REQ_SPARE, '0, '0, 1'b0, '0, '0, 1'b0, '0, '0, '0);
    send_release(32'hFFFF_FFFF, 32'd1);        // bad id is ignored
    send_release(32'd1, 32'hFFFF_FFFF);        // count beyond the held one frees
    send_call(1'b1, 32'd1);
    send_join(1'b0, 32'hDEAD_BEEF, 16'd1, 16'd0, 1'b1, 32'd0);   // no key part
    send_join(1'b1, 32'hFFFF_FFFF, 16'd0, 16'd0, 1'b1, 32'd0);   // empty set
    send_join(1'b1, 32'd7, 16'd9, 16'd0, 1'b1, 32'd0);           // too many parts
    send_join(1'b1, 32'd7, 16'hFFFF, 16'hFFFF, 1'b1, 32'd0);     // part number too high
    send_join(1'b1, 32'd0, 16'd1, 16'd0, 1'b1, 32'd0);           // one-part set joins
    send_join(1'b1, 32'd9, 16'd2, 16'd1, 1'b1, 32'd0);
    send_join(1'b1, 32'd9, 16'd2, 16'd1, 1'b1, 32'd0);           // duplicate part
    send_join(1'b1, 32'd9, 16'd3, 16'd0, 1'b1, 32'd0);           // total disagrees
    send_join(1'b1, 32'd9, 16'd2, 16'd0, 1'b1, 32'd2);           // targets differ
    // Occupy every join slot, then one more key finds none.
    for (int k = 0; k < JOIN_SLOTS; k++) send_join(1'b1, 32'd20 + k, 16'd2, 16'd0, 1'b1, 32'd0);
    send_join(1'b1, 32'd30, 16'd2, 16'd0, 1'b1, 32'd0);
    for (int k = 0; k < JOIN_SLOTS; k++) send_join(1'b1, 32'd20 + k, 16'd2, 16'd1, 1'b1, 32'd0);
    drain();

    write_register(CFG_BOOT_PRESENT, 16'd1);
    write_register(CFG_BOOT_SERVER, 16'hFFFF);
    send_request(REQ_BOOT, '0, '0, 1'b0, '0, '0, 1'b0, '0, '0, '0);
    // Fill the export table, then exports and bootstrap of new servers fail.
    for (int s = 1; s <= EXPORT_ENTRIES; s++) send_export(16'(s * 97));
    write_register(CFG_BOOT_SERVER, 16'h1234);
    send_request(REQ_BOOT, '0, '0, 1'b0, '0, '0, 1'b0, '0, '0, '0);
    send_export(16'h4321);
    // Raise the count of entry 0, then release it step by step.
    idle_pct = 0;
    for (int n = 0; n < 3; n++) send_export(16'd0);
    send_release(32'd0, 32'd2);                // a partial release keeps the entry
    send_call(1'b1, 32'd0);
    send_release(32'd0, 32'd1);
    send_call(1'b1, 32'd0);
    for (e = 0; e < EXPORT_ENTRIES; e++) send_release(e, 32'hFFFF_FFFF);
    drain();

    write_register(CFG_BOOT_SERVER, 16'($urandom));
    run_phase(23, 60);
    drain();
    write_register(CFG_BOOT_PRESENT, 16'd0);
    write_register(CFG_BOOT_SERVER, 16'd0);
    run_phase(67, 60);
    drain();
    write_register(CFG_BOOT_PRESENT, 16'd1);
    write_register(CFG_BOOT_SERVER, 16'hFFFF);
    run_phase(0, 60);
    drain();
    // A completing join of the widest set keeps the block busy while it checks and emits its parts.
    repeat (40) @(posedge clk_i);

    $display("Sent %0d requests and checked %0d results, %0d joins handing out a capability.",
             requests_sent, answers_seen, joins_won);
    if (fail_count == 0 && pending == 0) begin
      $display("capability_export_and_join_table_core verification clean");
    end else begin
      $display("%0d mismatches, %0d answers missing", fail_count, pending);
      $display("capability_export_and_join_table_core verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/cejt_pkg.sv
rtl/core/cejt_ram.sv
rtl/core/cejt_ctrl.sv
rtl/core/cejt_datapath.sv
rtl/core/capability_export_and_join_table_core.sv
rtl/core/cejt_checker.sv
sim/cejt_checker.sv
sim/tb_capability_export_and_join_table_core.sv
